// ----- sv/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants for the multilevel feedback queue
// Slot states, operation codes, status codes and the cell command bus.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int SLOTS  = 64;
    localparam int LEVELS = 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NUM_SLICES = 4;

    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_RUNNABLE = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_SLEEPING = 2'd3;

    localparam logic [3:0] OP_CREATE = 4'd0;
    localparam logic [3:0] OP_PICK   = 4'd1;
    localparam logic [3:0] OP_TICK   = 4'd2;
    localparam logic [3:0] OP_YIELD  = 4'd3;
    localparam logic [3:0] OP_SLEEP  = 4'd4;
    localparam logic [3:0] OP_WAKEUP = 4'd5;
    localparam logic [3:0] OP_BOOST  = 4'd6;
    localparam logic [3:0] OP_SETLVL = 4'd7;
    localparam logic [3:0] OP_FREE   = 4'd8;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NONE    = 2'd1;
    localparam logic [1:0] STS_BADARG  = 2'd2;
    localparam logic [1:0] STS_RUNSTATE = 2'd3;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_CREATE, ACT_PICK, ACT_SETLVL, ACT_WAKE,
        ACT_BOOST, ACT_TICK, ACT_YIELD, ACT_SLEEP, ACT_FREE
    } act_t;

    typedef enum logic [2:0] {
        SEL_NONE, SEL_UNUSED, SEL_RUN_LVL, SEL_PID, SEL_INDEX
    } sel_t;

    typedef struct packed {
        act_t                              act;
        sel_t                              sel;
        logic [LVL_W-1:0]                  sel_level;
        logic [SLOT_W-1:0]                 sel_index;
        logic [15:0]                       pid;
        logic [LVL_W-1:0]                  level;
        logic [31:0]                       chan;
        logic [NUM_SLICES-1:0][7:0]        slices;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]        state;
        logic [LVL_W-1:0]  level;
        logic [15:0]       pid;
        logic [SLOT_W-1:0] index;
    } cell_rd_t;

endpackage

// ----- sv/mlfq_if.sv -----
// ----------------------------------------------------------------------------
// mlfq_in_if / mlfq_out_if: request and result channels
// Valid/ready channels carrying one scheduler operation or one result.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [5:0]  slot;
    logic [15:0] pid;
    logic [7:0]  level;
    logic [31:0] channel;

    modport source (output valid, output operation, output slot, output pid,
                    output level, output channel, input ready);
    modport sink   (input valid, input operation, input slot, input pid,
                    input level, input channel, output ready);
endinterface

interface mlfq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [15:0] chosen_pid;
    logic [1:0]  chosen_level;

    modport source (output valid, output status, output chosen_slot,
                    output chosen_pid, output chosen_level, input ready);
    modport sink   (input valid, input status, input chosen_slot,
                    input chosen_pid, input chosen_level, output ready);
endinterface

// ----- sv/mlfq_cell.sv -----
// ----------------------------------------------------------------------------
// mlfq_cell: one slot of the scheduler table
// Holds a slot's state, level, ticks, pid and channel; joins the priority
// chain that picks the lowest matching slot and the read chain back.
// ----------------------------------------------------------------------------
module mlfq_cell
    import mlfq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] my_index,
    input  cell_cmd_t         cmd,
    input  logic              grant_in,
    output logic              grant_out,
    input  cell_rd_t          rd_in,
    output cell_rd_t          rd_out
);

    logic [1:0]       state_reg, state_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [7:0]       ticks_reg, ticks_next;
    logic [15:0]      pid_reg;
    logic [31:0]      chan_reg;
    logic             cand;
    logic             hit;
    logic [7:0]       ticks_inc;
    logic [1:0]       sidx;

    always_comb
    begin
        case (cmd.sel)
            SEL_UNUSED:  cand = (state_reg == ST_UNUSED);
            SEL_RUN_LVL: cand = (state_reg == ST_RUNNABLE) && (level_reg == cmd.sel_level);
            SEL_PID:     cand = (state_reg != ST_UNUSED) && (pid_reg == cmd.pid);
            default:     cand = 1'b0;
        endcase
        if (cmd.sel == SEL_INDEX)
            hit = (my_index == cmd.sel_index);
        else
            hit = cand && !grant_in;
    end

    assign grant_out = grant_in || cand;

    always_comb
    begin
        rd_out = rd_in;
        if (hit)
        begin
            rd_out.state = rd_in.state | state_reg;
            rd_out.level = rd_in.level | level_reg;
            rd_out.pid   = rd_in.pid | pid_reg;
            rd_out.index = rd_in.index | my_index;
        end
    end

    always_comb
    begin
        ticks_inc  = (ticks_reg < 8'd255) ? ticks_reg + 8'd1 : ticks_reg;
        sidx       = (int'(level_reg) < 3) ? 2'(level_reg) : 2'd3;
        state_next = state_reg;
        level_next = level_reg;
        ticks_next = ticks_reg;
        case (cmd.act)
            ACT_CREATE:
                if (hit)
                begin
                    state_next = ST_RUNNABLE;
                    level_next = '0;
                    ticks_next = '0;
                end
            ACT_PICK:
                if (hit)
                    state_next = ST_RUNNING;
            ACT_SETLVL:
                if (hit)
                begin
                    level_next = cmd.level;
                    ticks_next = '0;
                end
            ACT_WAKE:
                if (state_reg == ST_SLEEPING && chan_reg == cmd.chan)
                begin
                    state_next = ST_RUNNABLE;
                    level_next = '0;
                    ticks_next = '0;
                end
            ACT_BOOST:
                if (state_reg != ST_UNUSED)
                begin
                    level_next = '0;
                    ticks_next = '0;
                end
            ACT_TICK:
                if (hit)
                begin
                    if (ticks_inc >= cmd.slices[sidx])
                    begin
                        if (level_reg < LVL_W'(LEVELS - 1))
                            level_next = level_reg + LVL_W'(1);
                        ticks_next = '0;
                    end
                    else
                        ticks_next = ticks_inc;
                end
            ACT_YIELD:
                if (hit)
                    state_next = ST_RUNNABLE;
            ACT_SLEEP:
                if (hit)
                    state_next = ST_SLEEPING;
            ACT_FREE:
                if (hit)
                begin
                    state_next = ST_UNUSED;
                    level_next = '0;
                    ticks_next = '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_UNUSED;
            level_reg <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            ticks_reg <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act == ACT_CREATE && hit)
            pid_reg <= cmd.pid;
        if (cmd.act == ACT_SLEEP && hit)
            chan_reg <= cmd.chan;
    end

endmodule

// ----- sv/mlfq_process_scheduler.sv -----
// ----------------------------------------------------------------------------
// mlfq_process_scheduler: multilevel feedback queue over a slot table
// Sequencer that drives a chain of slot cells for each operation.
//
//   channel   dir   handshake        contents
//   in_ch     in    valid/ready      operation, slot, pid, level, channel
//   out_ch    out   valid/ready      status, chosen_slot, chosen_pid, chosen_level
//   cfg       in    cfg_wen          cfg_index, cfg_value (slice per level)
//
// Result path: an early status goes from evaluation straight to done; an
// applied operation passes through apply; tick also passes a read state for
// its level. Pick rescans each empty level in turn, 0 up to LEVELS-1, via the cell priority chain.
// Input is ready again the cycle after the result loads.
// Reset clears every slot to unused at once; no clearing pass.
// A new operation is taken while a result waits in the output register;
// the sequencer holds its finished result until that register frees up.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler
    import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mlfq_in_if.sink     in_ch,
    mlfq_out_if.source  out_ch,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_value
);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_APPLY, S_READ, S_DONE} fsm_t;

    fsm_t                       state_reg, state_next;
    logic [3:0]                 op_reg;
    logic [5:0]                 slot_reg;
    logic [15:0]                pid_reg;
    logic [7:0]                 level_reg;
    logic [31:0]                chan_reg;
    logic [NUM_SLICES-1:0][7:0] slice_reg;
    logic [15:0]                next_pid_reg, next_pid_next;
    logic                       run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]          run_index_reg, run_index_next;
    logic [LVL_W-1:0]           scan_lvl_reg, scan_lvl_next;
    act_t                       act_reg, act_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic [5:0]                 res_slot_reg, res_slot_next;
    logic [15:0]                res_pid_reg, res_pid_next;
    logic [1:0]                 res_level_reg, res_level_next;
    logic                       out_valid_reg;
    logic [1:0]                 out_status_reg;
    logic [5:0]                 out_slot_reg;
    logic [15:0]                out_pid_reg;
    logic [1:0]                 out_level_reg;

    cell_cmd_t                  cmd;
    logic [SLOTS:0]             grant;
    cell_rd_t                   rd [SLOTS+1];
    logic                       found;
    cell_rd_t                   rd_res;
    logic                       load_out;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign found       = grant[SLOTS];
    assign rd_res      = rd[SLOTS];
    assign grant[0]    = 1'b0;
    assign rd[0]       = '0;

    always_comb
    begin
        cmd           = '0;
        cmd.act       = (state_reg == S_APPLY) ? act_reg : ACT_NONE;
        cmd.sel_level = scan_lvl_reg;
        cmd.sel_index = run_index_reg;
        // the counter has already advanced when create applies; use the captured pid
        cmd.pid       = (op_reg == OP_CREATE) ? res_pid_reg : pid_reg;
        cmd.level     = LVL_W'(level_reg);
        cmd.chan      = chan_reg;
        cmd.slices    = slice_reg;
        case (op_reg)
            OP_CREATE: cmd.sel = SEL_UNUSED;
            OP_PICK:   cmd.sel = SEL_RUN_LVL;
            OP_SETLVL: cmd.sel = SEL_PID;
            OP_TICK, OP_YIELD, OP_SLEEP: cmd.sel = SEL_INDEX;
            OP_FREE:
            begin
                cmd.sel       = SEL_INDEX;
                cmd.sel_index = SLOT_W'(slot_reg);
            end
            default:   cmd.sel = SEL_NONE;
        endcase
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        mlfq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_index  (SLOT_W'(g)),
            .cmd       (cmd),
            .grant_in  (grant[g]),
            .grant_out (grant[g+1]),
            .rd_in     (rd[g]),
            .rd_out    (rd[g+1])
        );
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        next_pid_next   = next_pid_reg;
        run_valid_next  = run_valid_reg;
        run_index_next  = run_index_reg;
        scan_lvl_next   = scan_lvl_reg;
        act_next        = act_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pid_next    = res_pid_reg;
        res_level_next  = res_level_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                begin
                    state_next      = S_EVAL;
                    scan_lvl_next   = '0;
                    act_next        = ACT_NONE;
                    res_status_next = STS_OK;
                    res_slot_next   = '0;
                    res_pid_next    = '0;
                    res_level_next  = '0;
                end
            S_EVAL:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_CREATE:
                        if (found)
                        begin
                            act_next      = ACT_CREATE;
                            state_next    = S_APPLY;
                            res_slot_next = 6'(rd_res.index);
                            res_pid_next  = next_pid_reg;
                            next_pid_next = next_pid_reg + 16'd1;
                        end
                        else
                            res_status_next = STS_NONE;
                    OP_PICK:
                        if (run_valid_reg)
                            res_status_next = STS_RUNSTATE;
                        else if (found)
                        begin
                            act_next       = ACT_PICK;
                            state_next     = S_APPLY;
                            res_slot_next  = 6'(rd_res.index);
                            res_pid_next   = rd_res.pid;
                            res_level_next = 2'(scan_lvl_reg);
                            run_valid_next = 1'b1;
                            run_index_next = rd_res.index;
                        end
                        else if (scan_lvl_reg == LVL_W'(LEVELS - 1))
                            res_status_next = STS_NONE;
                        else
                        begin
                            scan_lvl_next = scan_lvl_reg + LVL_W'(1);
                            state_next    = S_EVAL;
                        end
                    OP_TICK, OP_YIELD, OP_SLEEP:
                        if (!run_valid_reg)
                            res_status_next = STS_RUNSTATE;
                        else
                        begin
                            state_next = S_APPLY;
                            if (op_reg == OP_TICK)
                                act_next = ACT_TICK;
                            else
                            begin
                                act_next       = (op_reg == OP_YIELD) ? ACT_YIELD : ACT_SLEEP;
                                run_valid_next = 1'b0;
                            end
                        end
                    OP_WAKEUP:
                    begin
                        act_next   = ACT_WAKE;
                        state_next = S_APPLY;
                    end
                    OP_BOOST:
                    begin
                        act_next   = ACT_BOOST;
                        state_next = S_APPLY;
                    end
                    OP_SETLVL:
                        if (int'(level_reg) >= LEVELS)
                            res_status_next = STS_BADARG;
                        else if (found)
                        begin
                            act_next   = ACT_SETLVL;
                            state_next = S_APPLY;
                        end
                        else
                            res_status_next = STS_NONE;
                    OP_FREE:
                        if (int'(slot_reg) >= SLOTS)
                            res_status_next = STS_BADARG;
                        else if (rd_res.state == ST_RUNNING)
                            res_status_next = STS_RUNSTATE;
                        else
                        begin
                            act_next   = ACT_FREE;
                            state_next = S_APPLY;
                        end
                    default:
                        res_status_next = STS_BADARG;
                endcase
            end
            S_APPLY:
                state_next = (act_reg == ACT_TICK) ? S_READ : S_DONE;
            S_READ:
            begin
                res_level_next = 2'(rd_res.level);
                state_next     = S_DONE;
            end
            S_DONE:
                if (load_out)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_pid_reg  <= 16'd1;
            run_valid_reg <= 1'b0;
            run_index_reg <= '0;
            scan_lvl_reg  <= '0;
            act_reg       <= ACT_NONE;
            out_valid_reg <= 1'b0;
            slice_reg     <= {8'd8, 8'd4, 8'd2, 8'd1};
        end
        else
        begin
            state_reg     <= state_next;
            next_pid_reg  <= next_pid_next;
            run_valid_reg <= run_valid_next;
            run_index_reg <= run_index_next;
            scan_lvl_reg  <= scan_lvl_next;
            act_reg       <= act_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_wen)
                slice_reg[cfg_index] <= cfg_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg    <= in_ch.operation;
            slot_reg  <= in_ch.slot;
            pid_reg   <= in_ch.pid;
            level_reg <= in_ch.level;
            chan_reg  <= in_ch.channel;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pid_reg    <= res_pid_next;
        res_level_reg  <= res_level_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_pid_reg    <= res_pid_reg;
            out_level_reg  <= res_level_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.chosen_slot  = out_slot_reg;
    assign out_ch.chosen_pid   = out_pid_reg;
    assign out_ch.chosen_level = out_level_reg;

`ifndef SYNTH
    // a pick that applies leaves a slot running
    a_pick_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && act_reg == ACT_PICK) |-> run_valid_reg)
        else $error("pick applied without running slot");

    // pid counter moves only on a successful create
    a_pid_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_pid_reg != $past(next_pid_reg)) |->
        ($past(state_reg) == S_EVAL && $past(op_reg) == OP_CREATE))
        else $error("pid counter moved outside create");

    // a result enters the output register only from the done state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded outside done state");
`endif

endmodule
